### src/jcfp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jcfp_pkg
// Shared types and constants for the class file parser core.
// ----------------------------------------------------------------------------
package jcfp_pkg;

	localparam int unsigned MAX_STREAM_BYTES_DEF = 65536;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW = 2;

	// record kinds
	localparam logic [2:0] KIND_POOL   = 3'd0;
	localparam logic [2:0] KIND_HEADER = 3'd1;
	localparam logic [2:0] KIND_IFACE  = 3'd2;
	localparam logic [2:0] KIND_FIELD  = 3'd3;
	localparam logic [2:0] KIND_METHOD = 3'd4;
	localparam logic [2:0] KIND_DONE   = 3'd5;
	localparam logic [2:0] KIND_ERROR  = 3'd6;

	// error codes
	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_MAGIC = 2'd1;
	localparam logic [1:0] ERR_TAG   = 2'd2;
	localparam logic [1:0] ERR_EARLY = 2'd3;

	typedef struct packed {
		logic [2:0]  record_kind;
		logic [15:0] item_index;
		logic [7:0]  entry_tag;
		logic [15:0] access_flags;
		logic [15:0] first_index;
		logic [15:0] second_index;
		logic [31:0] word_value;
		logic [15:0] attribute_count;
		logic [1:0]  error_code;
	} rec_t;

endpackage
`default_nettype wire

### src/jcfp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jcfp_front
// Byte-wise parser: one state update per accepted byte, at most one record.
// ----------------------------------------------------------------------------
module jcfp_front #(
	parameter int unsigned MAX_STREAM_BYTES = jcfp_pkg::MAX_STREAM_BYTES_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	input  wire [7:0]         in_byte,
	input  wire               in_last,
	input  wire               in_ready,
	output logic              rec_valid,
	output jcfp_pkg::rec_t    rec
);

	localparam int unsigned OFF_W = $clog2(MAX_STREAM_BYTES + 1);
	localparam logic [OFF_W-1:0] OFF_MAX = OFF_W'(MAX_STREAM_BYTES);

	localparam logic [4:0] PH_MAGIC = 5'd0;
	localparam logic [4:0] PH_VERSION = 5'd1;
	localparam logic [4:0] PH_POOL_COUNT = 5'd2;
	localparam logic [4:0] PH_TAG = 5'd3;
	localparam logic [4:0] PH_BODY = 5'd4;
	localparam logic [4:0] PH_TEXT = 5'd5;
	localparam logic [4:0] PH_ACCESS = 5'd6;
	localparam logic [4:0] PH_THIS = 5'd7;
	localparam logic [4:0] PH_SUPER = 5'd8;
	localparam logic [4:0] PH_IFACE_COUNT = 5'd9;
	localparam logic [4:0] PH_IFACE = 5'd10;
	localparam logic [4:0] PH_FIELD_COUNT = 5'd11;
	localparam logic [4:0] PH_MEMBER = 5'd12;
	localparam logic [4:0] PH_ATTR_HEAD = 5'd13;
	localparam logic [4:0] PH_ATTR_BODY = 5'd14;
	localparam logic [4:0] PH_METHOD_COUNT = 5'd15;
	localparam logic [4:0] PH_TAIL = 5'd16;
	localparam logic [4:0] PH_DONE = 5'd17;
	localparam logic [4:0] PH_ERROR = 5'd18;

	localparam logic [7:0] TAG_UTF8 = 8'd1;
	localparam logic [7:0] TAG_INT = 8'd3;
	localparam logic [7:0] TAG_LONG = 8'd5;
	localparam logic [7:0] TAG_DOUBLE = 8'd6;
	localparam logic [7:0] TAG_CLASS = 8'd7;
	localparam logic [7:0] TAG_STRING = 8'd8;

	logic [4:0]       phase_q, n_phase;
	logic [3:0]       bif_q, n_bif;
	logic [31:0]      acc_q, n_acc;
	logic [31:0]      skip_q, n_skip;
	logic [OFF_W-1:0] off_q, n_off;
	logic [15:0]      pcount_q, n_pcount;
	logic [16:0]      pslot_q, n_pslot;
	logic [7:0]       tag_q, n_tag;
	logic [15:0]      lcount_q, n_lcount;
	logic [15:0]      lpos_q, n_lpos;
	logic [15:0]      attr_q, n_attr;
	logic [15:0]      hacc_q, n_hacc;
	logic [15:0]      hfirst_q, n_hfirst;
	logic [15:0]      hsecond_q, n_hsecond;
	logic             meth_q, n_meth;

	logic             accept;
	logic [31:0]      acc_sh;
	logic [3:0]       bif_p1;
	logic [3:0]       body_w;
	logic [15:0]      lpos_p1;
	logic [15:0]      attr_m1;
	logic [16:0]      slot_next;

	assign accept = in_valid && in_ready;
	assign acc_sh = {acc_q[23:0], in_byte};
	assign bif_p1 = bif_q + 4'd1;
	assign lpos_p1 = lpos_q + 16'd1;
	assign attr_m1 = attr_q - 16'd1;
	assign slot_next = pslot_q + ((tag_q == TAG_LONG || tag_q == TAG_DOUBLE) ? 17'd2 : 17'd1);

	// fixed body size after a tag, zero for unknown tags
	function automatic logic [3:0] body_bytes(input logic [7:0] t);
		case (t)
			8'd1, 8'd7, 8'd8, 8'd16: body_bytes = 4'd2;
			8'd3, 8'd4, 8'd9, 8'd10, 8'd11, 8'd12, 8'd18: body_bytes = 4'd4;
			8'd5, 8'd6: body_bytes = 4'd8;
			8'd15: body_bytes = 4'd3;
			default: body_bytes = 4'd0;
		endcase
	endfunction

	assign body_w = body_bytes(tag_q);

	// next-state and record logic for one byte
	always_comb begin
		n_phase = phase_q; n_bif = bif_q; n_acc = acc_q; n_skip = skip_q;
		n_off = off_q; n_pcount = pcount_q; n_pslot = pslot_q; n_tag = tag_q;
		n_lcount = lcount_q; n_lpos = lpos_q; n_attr = attr_q; n_hacc = hacc_q;
		n_hfirst = hfirst_q; n_hsecond = hsecond_q; n_meth = meth_q;
		rec_valid = 1'b0;
		rec = '0;

		if (phase_q != PH_DONE && phase_q != PH_ERROR && off_q >= OFF_MAX) begin
			rec_valid = 1'b1; rec.record_kind = jcfp_pkg::KIND_ERROR;
			rec.error_code = jcfp_pkg::ERR_EARLY; n_phase = PH_ERROR;
		end else begin
			case (phase_q)
				PH_MAGIC, PH_VERSION: begin
					n_acc = acc_sh;
					if (bif_p1 >= 4'd4) begin
						n_bif = '0;
						if (phase_q == PH_VERSION) n_phase = PH_POOL_COUNT;
						else if (acc_sh != 32'hCAFEBABE) begin
							rec_valid = 1'b1; rec.record_kind = jcfp_pkg::KIND_ERROR;
							rec.error_code = jcfp_pkg::ERR_MAGIC; n_phase = PH_ERROR;
						end else n_phase = PH_VERSION;
					end else n_bif = bif_p1;
				end
				PH_POOL_COUNT: begin
					n_acc = acc_sh;
					if (bif_p1 >= 4'd2) begin
						n_bif = '0; n_pcount = acc_sh[15:0]; n_pslot = 17'd1;
						n_phase = (acc_sh[15:0] <= 16'd1) ? PH_ACCESS : PH_TAG;
					end else n_bif = bif_p1;
				end
				PH_TAG: begin
					n_tag = in_byte;
					if (body_bytes(in_byte) == 4'd0) begin
						rec_valid = 1'b1; rec.record_kind = jcfp_pkg::KIND_ERROR;
						rec.error_code = jcfp_pkg::ERR_TAG; n_phase = PH_ERROR;
					end else n_phase = PH_BODY;
				end
				PH_BODY: begin
					n_acc = acc_sh;
					if (bif_p1 >= body_w) begin
						n_bif = '0;
						rec_valid = 1'b1;
						rec.record_kind = jcfp_pkg::KIND_POOL;
						rec.item_index = pslot_q[15:0];
						rec.entry_tag = tag_q;
						n_pslot = slot_next;
						n_phase = ({1'b0, slot_next} >= {2'b0, pcount_q}) ? PH_ACCESS : PH_TAG;
						case (tag_q)
							TAG_UTF8: begin
								rec.first_index = acc_sh[15:0];
								rec.word_value = 32'(off_q) + 32'd1;
								n_skip = {16'd0, acc_sh[15:0]};
								if (acc_sh[15:0] != 16'd0) begin
									n_pslot = pslot_q; n_phase = PH_TEXT;
								end
							end
							TAG_INT: rec.word_value = acc_sh;
							TAG_CLASS, TAG_STRING: rec.first_index = acc_sh[15:0];
							8'd9, 8'd10, 8'd11, 8'd12: begin
								rec.first_index = acc_sh[31:16];
								rec.second_index = acc_sh[15:0];
							end
							default: ;
						endcase
					end else n_bif = bif_p1;
				end
				PH_TEXT: begin
					n_skip = skip_q - 32'd1;
					if (skip_q == 32'd1) begin
						n_pslot = slot_next;
						n_phase = ({1'b0, slot_next} >= {2'b0, pcount_q}) ? PH_ACCESS : PH_TAG;
					end
				end
				PH_ACCESS, PH_THIS, PH_SUPER, PH_IFACE_COUNT, PH_IFACE,
				PH_FIELD_COUNT, PH_METHOD_COUNT: begin
					n_acc = acc_sh;
					if (bif_p1 >= 4'd2) begin
						n_bif = '0;
						case (phase_q)
							PH_ACCESS: begin n_hacc = acc_sh[15:0]; n_phase = PH_THIS; end
							PH_THIS: begin n_hfirst = acc_sh[15:0]; n_phase = PH_SUPER; end
							PH_SUPER: begin
								n_hsecond = acc_sh[15:0];
								rec_valid = 1'b1; rec.record_kind = jcfp_pkg::KIND_HEADER;
								rec.access_flags = hacc_q; rec.first_index = hfirst_q;
								rec.second_index = acc_sh[15:0];
								n_phase = PH_IFACE_COUNT;
							end
							PH_IFACE_COUNT: begin
								n_lcount = acc_sh[15:0]; n_lpos = '0;
								n_phase = (acc_sh[15:0] != 16'd0) ? PH_IFACE : PH_FIELD_COUNT;
							end
							PH_IFACE: begin
								rec_valid = 1'b1; rec.record_kind = jcfp_pkg::KIND_IFACE;
								rec.item_index = lpos_q; rec.first_index = acc_sh[15:0];
								n_lpos = lpos_p1;
								if (lpos_p1 >= lcount_q) n_phase = PH_FIELD_COUNT;
							end
							default: begin
								// field or method count opens a member list
								n_meth = (phase_q == PH_METHOD_COUNT);
								n_lcount = acc_sh[15:0]; n_lpos = '0;
								if (acc_sh[15:0] != 16'd0) n_phase = PH_MEMBER;
								else n_phase = (phase_q == PH_METHOD_COUNT) ? PH_TAIL
									: PH_METHOD_COUNT;
							end
						endcase
					end else n_bif = bif_p1;
				end
				PH_MEMBER: begin
					n_acc = acc_sh;
					if (bif_p1 >= 4'd8) begin
						n_bif = '0;
						n_attr = acc_sh[15:0];
						rec_valid = 1'b1;
						rec.record_kind = meth_q ? jcfp_pkg::KIND_METHOD : jcfp_pkg::KIND_FIELD;
						rec.item_index = lpos_q; rec.access_flags = hacc_q;
						rec.first_index = hfirst_q; rec.second_index = hsecond_q;
						rec.attribute_count = acc_sh[15:0];
						if (acc_sh[15:0] == 16'd0) begin
							n_lpos = lpos_p1;
							if (lpos_p1 < lcount_q) n_phase = PH_MEMBER;
							else n_phase = meth_q ? PH_TAIL : PH_METHOD_COUNT;
						end else n_phase = PH_ATTR_HEAD;
					end else begin
						n_bif = bif_p1;
						if (bif_p1 == 4'd2) n_hacc = acc_sh[15:0];
						else if (bif_p1 == 4'd4) n_hfirst = acc_sh[15:0];
						else if (bif_p1 == 4'd6) n_hsecond = acc_sh[15:0];
					end
				end
				PH_ATTR_HEAD, PH_ATTR_BODY: begin
					// attribute done when the length is zero or the body ends
					logic fin;
					fin = 1'b0;
					if (phase_q == PH_ATTR_HEAD) begin
						n_acc = acc_sh;
						if (bif_p1 >= 4'd6) begin
							n_bif = '0; n_skip = acc_sh;
							if (acc_sh == 32'd0) fin = 1'b1;
							else n_phase = PH_ATTR_BODY;
						end else n_bif = bif_p1;
					end else begin
						n_skip = skip_q - 32'd1;
						fin = (skip_q == 32'd1);
					end
					if (fin) begin
						n_attr = attr_m1;
						if (attr_m1 == 16'd0) begin
							n_lpos = lpos_p1;
							if (lpos_p1 < lcount_q) n_phase = PH_MEMBER;
							else n_phase = meth_q ? PH_TAIL : PH_METHOD_COUNT;
						end else n_phase = PH_ATTR_HEAD;
					end
				end
				PH_TAIL: begin
					rec_valid = 1'b1; rec.record_kind = jcfp_pkg::KIND_DONE;
					n_phase = PH_DONE;
				end
				default: ;
			endcase
		end

		if (off_q < OFF_MAX) n_off = off_q + OFF_W'(1);

		// final byte: flag early end, then restart for a new file
		if (in_last) begin
			if (n_phase != PH_DONE && n_phase != PH_ERROR) begin
				rec_valid = 1'b1; rec = '0;
				rec.record_kind = jcfp_pkg::KIND_ERROR;
				rec.error_code = jcfp_pkg::ERR_EARLY;
			end
			n_phase = PH_MAGIC; n_bif = '0; n_acc = '0; n_skip = '0; n_off = '0;
			n_pcount = '0; n_pslot = '0; n_tag = '0; n_lcount = '0; n_lpos = '0;
			n_attr = '0; n_hacc = '0; n_hfirst = '0; n_hsecond = '0; n_meth = 1'b0;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC; bif_q <= '0; acc_q <= '0; skip_q <= '0; off_q <= '0;
			pcount_q <= '0; pslot_q <= '0; tag_q <= '0; lcount_q <= '0; lpos_q <= '0;
			attr_q <= '0; hacc_q <= '0; hfirst_q <= '0; hsecond_q <= '0; meth_q <= 1'b0;
		end else if (accept) begin
			phase_q <= n_phase; bif_q <= n_bif; acc_q <= n_acc; skip_q <= n_skip;
			off_q <= n_off; pcount_q <= n_pcount; pslot_q <= n_pslot; tag_q <= n_tag;
			lcount_q <= n_lcount; lpos_q <= n_lpos; attr_q <= n_attr; hacc_q <= n_hacc;
			hfirst_q <= n_hfirst; hsecond_q <= n_hsecond; meth_q <= n_meth;
		end
	end

endmodule
`default_nettype wire

### src/jcfp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jcfp_queue
// Short record queue between the parser and the output side.
// ----------------------------------------------------------------------------
module jcfp_queue (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push,
	input  jcfp_pkg::rec_t  push_rec,
	output logic            full,
	output logic            out_valid,
	input  wire             out_ready,
	output jcfp_pkg::rec_t  out_rec
);

	localparam int unsigned AW = jcfp_pkg::QUEUE_AW;

	jcfp_pkg::rec_t mem_q [jcfp_pkg::QUEUE_DEPTH];
	logic [AW-1:0]  wr_q, rd_q;
	logic [AW:0]    cnt_q;
	logic           pop;

	assign full = (cnt_q == (AW+1)'(jcfp_pkg::QUEUE_DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_rec = mem_q[rd_q];
	assign pop = out_valid && out_ready;

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_rec;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + AW'(1);
			if (pop) rd_q <= rd_q + AW'(1);
			if (push && !pop) cnt_q <= cnt_q + (AW+1)'(1);
			else if (pop && !push) cnt_q <= cnt_q - (AW+1)'(1);
		end
	end

endmodule
`default_nettype wire

### src/java_class_file_parser_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// java_class_file_parser_core
// Streaming class file parser: bytes in, one record per parsed entity out.
// ----------------------------------------------------------------------------
// Takes one class file byte per cycle and emits pool, header, interface,
// field, method, done and error records with raw indices. Each byte makes
// one update of the parser state machine; records pass through a four-entry
// queue, so input keeps flowing at one byte per cycle while the queue has
// room, and stalls only when the output side holds it full.
module java_class_file_parser_core #(
	parameter int unsigned MAX_STREAM_BYTES = jcfp_pkg::MAX_STREAM_BYTES_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire  [7:0]   s_tdata,   // data_byte
	input  wire          s_tlast,   // last_byte
	output logic         m_tvalid,
	input  wire          m_tready,
	// item_index, entry_tag, access_flags, first_index, second_index,
	// word_value, attribute_count, error_code, zero fill
	output logic [127:0] m_tdata,
	output logic [2:0]   m_tuser    // record_kind
);

	logic           rec_valid;
	logic           q_full;
	jcfp_pkg::rec_t rec, out_rec;

	assign s_tready = !q_full;

	jcfp_front #(.MAX_STREAM_BYTES(MAX_STREAM_BYTES)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_byte(s_tdata),
		.in_last(s_tlast), .in_ready(s_tready), .rec_valid(rec_valid), .rec(rec)
	);

	jcfp_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(s_tvalid && s_tready && rec_valid),
		.push_rec(rec), .full(q_full), .out_valid(m_tvalid), .out_ready(m_tready),
		.out_rec(out_rec)
	);

	// output packing
	assign m_tuser = out_rec.record_kind;
	assign m_tdata = {6'd0, out_rec.error_code, out_rec.attribute_count,
		out_rec.word_value, out_rec.second_index, out_rec.first_index,
		out_rec.access_flags, out_rec.entry_tag, out_rec.item_index};

`ifndef SYNTHESIS
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser <= jcfp_pkg::KIND_ERROR)
		else $error("record kind out of range");
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == jcfp_pkg::KIND_ERROR) |-> m_tdata[121:120] != 2'd0)
		else $error("error record without code");
	a_no_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != jcfp_pkg::KIND_ERROR) |-> m_tdata[121:120] == 2'd0)
		else $error("error code on normal record");
`endif

endmodule
`default_nettype wire
